// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define NLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// same-cycle implication
`define NLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NLC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/nlc_pkg.sv =====
// ----------------------------------------------------------------------------
// nlc_pkg
// types and constants of the numeric literal classifier
// ----------------------------------------------------------------------------
package nlc_pkg;

    // longest literal accepted
    localparam int MAX_LEN = 255;
    localparam int LEN_CAP = (MAX_LEN < 255) ? MAX_LEN : 255;

    // scanner phase, one-hot
    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_BEGIN     = 9'b000000010,
        PH_SIGNED    = 9'b000000100,
        PH_INT       = 9'b000001000,
        PH_PERIOD    = 9'b000010000,
        PH_FRAC      = 9'b000100000,
        PH_EXP_START = 9'b001000000,
        PH_EXP_SIGN  = 9'b010000000,
        PH_EXP_DIG   = 9'b100000000
    } phase_t;

    // result classes
    typedef enum logic [2:0] {
        CLS_NONE     = 3'd0,
        CLS_UINT     = 3'd1,
        CLS_SINT     = 3'd2,
        CLS_UDEC     = 3'd3,
        CLS_SDEC     = 3'd4,
        CLS_APPROX   = 3'd5
    } token_class_t;

    // scanner state carried between items
    typedef struct packed {
        phase_t     phase;
        logic       sign_seen;
        logic [7:0] char_count;
    } nlc_state_t;

    // result of one step
    typedef struct packed {
        logic         emit;
        token_class_t token_class;
        logic [7:0]   token_length;
    } nlc_result_t;

endpackage

// ===== sv/nlc_step.sv =====
// ----------------------------------------------------------------------------
// nlc_step
// one character of the literal scanner: next state and optional result
// ----------------------------------------------------------------------------
module nlc_step (
    input  nlc_pkg::nlc_state_t  state_in,
    input  logic [7:0]           char_code,
    input  logic                 restart,
    input  logic                 end_of_text,
    output nlc_pkg::nlc_state_t  state_out,
    output nlc_pkg::nlc_result_t result
);

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_EXP    = 8'h45;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // class and length when the candidate ends in a given phase
    function automatic nlc_pkg::nlc_result_t finish(
        input nlc_pkg::phase_t ph,
        input logic            sg,
        input logic [7:0]      cnt
    );
        nlc_pkg::nlc_result_t r;
        r.emit = 1'b1;
        unique case (ph)
            nlc_pkg::PH_EXP_DIG: r.token_class = nlc_pkg::CLS_APPROX;
            nlc_pkg::PH_FRAC:    r.token_class = sg ? nlc_pkg::CLS_SDEC : nlc_pkg::CLS_UDEC;
            nlc_pkg::PH_INT:     r.token_class = sg ? nlc_pkg::CLS_SINT : nlc_pkg::CLS_UINT;
            default:             r.token_class = nlc_pkg::CLS_NONE;
        endcase
        r.token_length = (r.token_class != nlc_pkg::CLS_NONE) ? cnt : 8'd0;
        return r;
    endfunction

    nlc_pkg::phase_t ph;
    nlc_pkg::phase_t np;
    logic            sg;
    logic            np_sg;
    logic [7:0]      cnt;
    logic [7:0]      cnt_inc;
    logic            is_digit;
    logic            is_sign;
    logic            is_term;

    // character classes
    always_comb begin
        is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
        is_term  = (char_code == CH_SPACE) ||
                   ((char_code >= CH_TAB) && (char_code <= CH_CR)) ||
                   (char_code == CH_COMMA) || (char_code == CH_LPAREN) ||
                   (char_code == CH_RPAREN) || (char_code == CH_SEMI);
    end

    // restart opens a fresh candidate
    always_comb begin
        ph      = restart ? nlc_pkg::PH_BEGIN : state_in.phase;
        sg      = restart ? 1'b0 : state_in.sign_seen;
        cnt     = restart ? 8'd0 : state_in.char_count;
        cnt_inc = cnt + 8'd1;
    end

    // phase transition on a non-terminator
    always_comb begin
        np    = nlc_pkg::PH_IDLE;
        np_sg = sg;
        unique case (ph)
            nlc_pkg::PH_BEGIN, nlc_pkg::PH_SIGNED: begin
                if (is_sign && (ph == nlc_pkg::PH_BEGIN)) begin
                    np    = nlc_pkg::PH_SIGNED;
                    np_sg = 1'b1;
                end else if (is_digit) begin
                    np = nlc_pkg::PH_INT;
                end else if (char_code == CH_PERIOD) begin
                    np = nlc_pkg::PH_PERIOD;
                end
            end
            nlc_pkg::PH_INT: begin
                if (is_digit) begin
                    np = nlc_pkg::PH_INT;
                end else if (char_code == CH_PERIOD) begin
                    np = nlc_pkg::PH_PERIOD;
                end else if (char_code == CH_EXP) begin
                    np = nlc_pkg::PH_EXP_START;
                end
            end
            nlc_pkg::PH_PERIOD: begin
                if (is_digit) np = nlc_pkg::PH_FRAC;
            end
            nlc_pkg::PH_FRAC: begin
                if (is_digit) begin
                    np = nlc_pkg::PH_FRAC;
                end else if (char_code == CH_EXP) begin
                    np = nlc_pkg::PH_EXP_START;
                end
            end
            nlc_pkg::PH_EXP_START: begin
                if (is_sign) begin
                    np = nlc_pkg::PH_EXP_SIGN;
                end else if (is_digit) begin
                    np = nlc_pkg::PH_EXP_DIG;
                end
            end
            nlc_pkg::PH_EXP_SIGN, nlc_pkg::PH_EXP_DIG: begin
                if (is_digit) np = nlc_pkg::PH_EXP_DIG;
            end
            default: np = nlc_pkg::PH_IDLE;
        endcase
    end

    // outcome of the item
    always_comb begin
        state_out.phase      = nlc_pkg::PH_IDLE;
        state_out.sign_seen  = sg;
        state_out.char_count = cnt;
        result.emit          = 1'b0;
        result.token_class   = nlc_pkg::CLS_NONE;
        result.token_length  = 8'd0;
        priority if (ph == nlc_pkg::PH_IDLE) begin
            // ignored while idle
        end else if (is_term) begin
            result = finish(ph, sg, cnt);
        end else if (cnt >= 8'(nlc_pkg::LEN_CAP)) begin
            result.emit = 1'b1;
        end else if (np == nlc_pkg::PH_IDLE) begin
            state_out.char_count = cnt_inc;
            result.emit          = 1'b1;
        end else begin
            state_out.sign_seen  = np_sg;
            state_out.char_count = cnt_inc;
            if (end_of_text) begin
                result = finish(np, np_sg, cnt_inc);
            end else begin
                state_out.phase = np;
            end
        end
    end

endmodule

// ===== sv/numeric_literal_classifier_top.sv =====
// a character passes the input register, then the result register, before its result is valid
// throughput: one character per cycle; the scanner state updates in a single pass
// per item, and the stage only stalls while the result register is full and not taken
// reset: synchronous active-low aresetn empties both registers and returns the
// scanner to idle, waiting for a character with restart set
// ----------------------------------------------------------------------------
// numeric_literal_classifier_top
// streaming classifier of numeric literals, one character per item
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module numeric_literal_classifier_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_restart,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_class,
    output logic [7:0] m_token_length
);

    logic                 in_valid_reg;
    logic [7:0]           char_reg;
    logic                 restart_reg;
    logic                 eot_reg;
    nlc_pkg::nlc_state_t  state_reg;
    nlc_pkg::nlc_state_t  state_next;
    nlc_pkg::nlc_result_t step_result;
    logic                 out_valid_reg;
    logic [2:0]           class_reg;
    logic [7:0]           length_reg;
    logic                 advance;

    // stage moves when the result register has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            char_reg    <= s_char_code;
            restart_reg <= s_restart;
            eot_reg     <= s_end_of_text;
        end
    end

    nlc_step u_step (
        .state_in    (state_reg),
        .char_code   (char_reg),
        .restart     (restart_reg),
        .end_of_text (eot_reg),
        .state_out   (state_next),
        .result      (step_result)
    );

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= nlc_pkg::PH_IDLE;
            state_reg.sign_seen  <= 1'b0;
            state_reg.char_count <= 8'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_result.emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && step_result.emit) begin
            class_reg  <= step_result.token_class;
            length_reg <= step_result.token_length;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_token_class  = class_reg;
    assign m_token_length = length_reg;

    // checks
    `NLC_ASSERT(a_phase_onehot, $onehot(state_reg.phase), "scanner phase not one-hot")
    `NLC_ASSERT_NXT(a_state_hold, !advance, $stable(state_reg), "state moved without an item")
    `NLC_ASSERT_IMP(a_none_len, m_valid && (class_reg == nlc_pkg::CLS_NONE),
        length_reg == 8'd0, "not-found result with nonzero length")
    `NLC_ASSERT_IMP(a_found_len, m_valid && (class_reg != nlc_pkg::CLS_NONE),
        length_reg != 8'd0, "literal with zero length")
    `NLC_ASSERT_IMP(a_approx_len, m_valid && (class_reg == nlc_pkg::CLS_APPROX),
        length_reg >= 8'd3, "approximate number shorter than three characters")

endmodule

// ===== tb/sv/literal_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_result_checker
// watches both channels of the numeric literal classifier, predicts the
// class and length of every literal from the accepted characters and
// compares each result item, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module literal_result_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_restart,
    input  logic       s_end_of_text,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_token_class,
    input  logic [7:0] m_token_length,
    output int         error_count,
    output int         pending_count
);

    // characters with a meaning of their own
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_EXP    = 8'h45;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_BEGIN,
        SCAN_SIGNED,
        SCAN_INT,
        SCAN_PERIOD,
        SCAN_FRAC,
        SCAN_EXP_START,
        SCAN_EXP_SIGN,
        SCAN_EXP_DIG
    } scan_phase_e;

    typedef struct packed {
        nlc_pkg::token_class_t cls;
        logic [7:0]            len;
    } literal_result_t;

    scan_phase_e     scan_phase = SCAN_IDLE;
    logic            scan_signed = 1'b0;
    logic [7:0]      scan_len = 8'd0;
    literal_result_t expected_literals[$];
    int              mismatches = 0;

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // whitespace and the four punctuation marks end a literal
    function automatic bit is_separator(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) ||
               (c == CH_COMMA) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
               (c == CH_SEMI);
    endfunction

    // class of the literal scanned so far, scanner back to idle
    function automatic literal_result_t close_literal();
        literal_result_t r;
        case (scan_phase)
            SCAN_EXP_DIG: r.cls = nlc_pkg::CLS_APPROX;
            SCAN_FRAC:    r.cls = scan_signed ? nlc_pkg::CLS_SDEC : nlc_pkg::CLS_UDEC;
            SCAN_INT:     r.cls = scan_signed ? nlc_pkg::CLS_SINT : nlc_pkg::CLS_UINT;
            default:      r.cls = nlc_pkg::CLS_NONE;
        endcase
        r.len = (r.cls == nlc_pkg::CLS_NONE) ? 8'd0 : scan_len;
        scan_phase = SCAN_IDLE;
        return r;
    endfunction

    function automatic literal_result_t reject_literal();
        literal_result_t r;
        r.cls = nlc_pkg::CLS_NONE;
        r.len = 8'd0;
        scan_phase = SCAN_IDLE;
        return r;
    endfunction

    // grammar step; idle means the character breaks the literal
    function automatic scan_phase_e advance_phase(input logic [7:0] c);
        case (scan_phase)
            SCAN_BEGIN, SCAN_SIGNED: begin
                if (scan_phase == SCAN_BEGIN && is_sign(c)) begin
                    scan_signed = 1'b1;
                    return SCAN_SIGNED;
                end
                if (is_digit(c)) return SCAN_INT;
                if (c == CH_PERIOD) return SCAN_PERIOD;
                return SCAN_IDLE;
            end
            SCAN_INT: begin
                if (is_digit(c)) return SCAN_INT;
                if (c == CH_PERIOD) return SCAN_PERIOD;
                if (c == CH_EXP) return SCAN_EXP_START;
                return SCAN_IDLE;
            end
            SCAN_PERIOD: return is_digit(c) ? SCAN_FRAC : SCAN_IDLE;
            SCAN_FRAC: begin
                if (is_digit(c)) return SCAN_FRAC;
                if (c == CH_EXP) return SCAN_EXP_START;
                return SCAN_IDLE;
            end
            SCAN_EXP_START: begin
                if (is_sign(c)) return SCAN_EXP_SIGN;
                return is_digit(c) ? SCAN_EXP_DIG : SCAN_IDLE;
            end
            SCAN_EXP_SIGN, SCAN_EXP_DIG: return is_digit(c) ? SCAN_EXP_DIG : SCAN_IDLE;
            default: return SCAN_IDLE;
        endcase
    endfunction

    // one accepted character, zero or one literal result expected
    function automatic void classify_char(input logic [7:0] c, input logic rs,
                                          input logic last);
        scan_phase_e nxt;
        if (rs) begin
            scan_phase  = SCAN_BEGIN;
            scan_signed = 1'b0;
            scan_len    = 8'd0;
        end
        if (scan_phase == SCAN_IDLE) return;
        if (is_separator(c)) begin
            expected_literals.push_back(close_literal());
            return;
        end
        if (scan_len >= nlc_pkg::LEN_CAP) begin
            expected_literals.push_back(reject_literal());
            return;
        end
        scan_len = scan_len + 8'd1;
        nxt = advance_phase(c);
        if (nxt == SCAN_IDLE) begin
            expected_literals.push_back(reject_literal());
            return;
        end
        scan_phase = nxt;
        if (last) expected_literals.push_back(close_literal());
    endfunction

    // compare results first, then predict from the character taken this edge
    always @(posedge aclk) begin
        literal_result_t want;
        if (!aresetn) begin
            scan_phase  = SCAN_IDLE;
            scan_signed = 1'b0;
            scan_len    = 8'd0;
            expected_literals.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_literals.size() == 0) begin
                    $error("unexpected result: token_class %0d token_length %0d",
                           m_token_class, m_token_length);
                    mismatches++;
                end else begin
                    want = expected_literals.pop_front();
                    if (m_token_class !== want.cls) begin
                        $error("token_class expected %0d actual %0d",
                               want.cls, m_token_class);
                        mismatches++;
                    end
                    if (m_token_length !== want.len) begin
                        $error("token_length expected %0d actual %0d",
                               want.len, m_token_length);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) classify_char(s_char_code, s_restart, s_end_of_text);
        end
        error_count   <= mismatches;
        pending_count <= expected_literals.size();
    end

endmodule

// ===== tb/sv/tb_numeric_literal_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_numeric_literal_classifier_top
// feeds the classifier directed and random text (well-formed literals with
// random content, corrupted literals, garbage, dropped candidates, an overlong
// digit run) under changing idle patterns and a long receiver stall; the
// checker beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_numeric_literal_classifier_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TOTAL_ITEMS  = 550;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_RUN     = 255;
    // leave room for the overlong run at the end
    localparam int RANDOM_ITEMS = TOTAL_ITEMS - LONG_RUN - 2;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_EXP    = 8'h45;
    localparam logic [7:0] CH_EXP_LC = 8'h65;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_code;
    logic       s_restart;
    logic       s_end_of_text;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_token_class;
    logic [7:0] m_token_length;

    int  error_count;
    int  pending_count;
    int  cycle_count = 0;
    int  sent_items = 0;
    int  send_idle_pct = 12;
    int  recv_idle_pct = 84;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    logic [7:0] lit_buf[$];
    // space, tab, lf, vt, ff, cr, comma, parentheses, semicolon
    logic [7:0] separators[10] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                                   8'h2C, 8'h28, 8'h29, 8'h3B};

    numeric_literal_classifier_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_restart      (s_restart),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_class  (m_token_class),
        .m_token_length (m_token_length)
    );

    literal_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_restart      (s_restart),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_class  (m_token_class),
        .m_token_length (m_token_length),
        .error_count    (error_count),
        .pending_count  (pending_count)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result receiver, with one long hold-off
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // one character item, held until accepted
    task automatic push_char(input logic [7:0] c, input logic rs, input logic eot,
                             input bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= c;
        s_restart     <= rs;
        s_end_of_text <= eot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (counted) sent_items++;
    endtask

    // first count characters of the buffer, restart on the first
    task automatic send_buffer(input int count, input bit eot_last);
        for (int i = 0; i < count; i++)
            push_char(lit_buf[i], i == 0, eot_last && (i == count - 1), 1'b1);
    endtask

    task automatic send_text(input string txt, input bit eot_last);
        lit_buf.delete();
        for (int i = 0; i < txt.len(); i++) lit_buf.push_back(txt[i]);
        send_buffer(lit_buf.size(), eot_last);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_sign();
        return $urandom_range(1) ? CH_PLUS : CH_MINUS;
    endfunction

    // well-formed literal: optional sign, mantissa with optional period, optional exponent
    function automatic void build_literal();
        int shape;
        lit_buf.delete();
        if ($urandom_range(2) != 0) lit_buf.push_back(rand_sign());
        shape = $urandom_range(2);
        if (shape != 2) repeat ($urandom_range(1, 6)) lit_buf.push_back(rand_digit());
        if (shape != 0) begin
            lit_buf.push_back(CH_PERIOD);
            repeat ($urandom_range(1, 4)) lit_buf.push_back(rand_digit());
        end
        if ($urandom_range(2) == 0) begin
            lit_buf.push_back(CH_EXP);
            if ($urandom_range(1)) lit_buf.push_back(rand_sign());
            repeat ($urandom_range(1, 3)) lit_buf.push_back(rand_digit());
        end
    endfunction

    // break a well-formed literal in one of several ways
    function automatic void corrupt_literal();
        int pos;
        pos = $urandom_range(lit_buf.size() - 1);
        case ($urandom_range(5))
            0: lit_buf[pos] = 8'($urandom_range(255));
            1: lit_buf.insert(pos, CH_PERIOD);
            2: lit_buf.push_back(CH_PERIOD);
            3: lit_buf.push_back(CH_EXP);
            4: lit_buf.insert(pos, CH_EXP_LC);
            default: lit_buf.insert(pos, rand_sign());
        endcase
    endfunction

    function automatic void build_garbage();
        lit_buf.delete();
        repeat ($urandom_range(1, 4)) lit_buf.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_digit_run(input int count);
        lit_buf.delete();
        repeat (count) lit_buf.push_back(rand_digit());
    endfunction

    // send the buffer, end it by end of text or a separator, sometimes idle text after
    task automatic send_literal();
        bit eot_last;
        eot_last = 1'($urandom_range(1));
        send_buffer(lit_buf.size(), eot_last);
        if (!eot_last)
            push_char(separators[$urandom_range(9)], 1'b0, 1'($urandom_range(1)), 1'b1);
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 2))
                push_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
    endtask

    // stimulus and verdict
    initial begin
        int mode;
        int pick;
        mode = 0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_char_code   <= 8'd0;
        s_restart     <= 1'b0;
        s_end_of_text <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle character, separator first, sign then separator,
        // every class, trailing period, lowercase e, dropped candidate
        push_char("x", 1'b0, 1'b1, 1'b0);
        send_text(";", 1'b0);
        send_text("- ", 1'b0);
        send_text("7,", 1'b0);
        send_text("+9)", 1'b0);
        send_text("12.5(", 1'b0);
        send_text("-.5", 1'b1);
        send_text("1.5E-3", 1'b1);
        send_text("1.", 1'b1);
        send_text("1e5", 1'b1);
        lit_buf.delete();
        lit_buf.push_back(8'hFF);
        send_buffer(1, 1'b1);
        send_text("5", 1'b0);
        send_text("8", 1'b1);

        // random text under three idle patterns
        while (sent_items < RANDOM_ITEMS) begin
            if (mode == 0 && sent_items >= RANDOM_ITEMS / 3) begin
                mode = 1;
                send_idle_pct = 84;
                recv_idle_pct = 12;
            end else if (mode == 1 && sent_items >= 2 * RANDOM_ITEMS / 3) begin
                mode = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                build_literal();
                send_literal();
            end else if (pick < 85) begin
                build_literal();
                corrupt_literal();
                send_literal();
            end else if (pick < 95) begin
                build_garbage();
                send_literal();
            end else begin
                // candidate abandoned halfway, the next restart drops it
                build_literal();
                send_buffer((lit_buf.size() + 1) / 2, 1'b0);
            end
        end

        // one character beyond the longest literal
        build_digit_run(LONG_RUN + 1);
        send_literal();

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
